// File: hw/rtl/eab_pkg.sv
// Package for the Euler angle to basis vector block: widths, CORDIC
// arctangent table, rounding helpers. No dependencies.
`timescale 1ns / 1ps
package eab_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int IN_W = 16;
    localparam int OUT_W = 16;
    localparam int Q_SHIFT = 30;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

    typedef logic signed [CW-1:0] q_t;
    typedef logic signed [OUT_W-1:0] comp_t;

    typedef struct packed {
        q_t sp; q_t cp; q_t sy; q_t cy; q_t sr; q_t cr;
    } trig_t;

    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
            5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
            5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
            5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
            5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001; default: t = 32'h00000000;
        endcase
        return CW'(signed'({1'b0, t}));
    endfunction

    // Round a 68-bit product back to Q3.30
    function automatic q_t qround(input logic signed [2*CW-1:0] p);
        logic signed [2*CW-1:0] r;
        r = (p + (68'sd1 <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
        return r[CW-1:0];
    endfunction

    function automatic comp_t to_field(input q_t v);
        localparam int SH = Q_SHIFT - VECTOR_FRAC_BITS;
        localparam logic signed [CW-1:0] LIM = CW'(1) <<< VECTOR_FRAC_BITS;
        logic signed [CW-1:0] r;
        r = (v + (CW'(1) <<< (SH - 1))) >>> SH;
        if (r > LIM) r = LIM;
        if (r < -LIM) r = -LIM;
        return r[OUT_W-1:0];
    endfunction
endpackage

// File: hw/rtl/eab_if.sv
// Valid/ready channel interfaces for the angle input and basis output.
// Depends on eab_pkg.
`timescale 1ns / 1ps
interface eab_in_if import eab_pkg::*; ();
    logic valid;
    logic ready;
    logic [IN_W-1:0] pitch_angle;
    logic [IN_W-1:0] yaw_angle;
    logic [IN_W-1:0] roll_angle;
    modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
    modport sink (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface eab_out_if import eab_pkg::*; ();
    logic valid;
    logic ready;
    comp_t forward_x, forward_y, forward_z;
    comp_t right_x, right_y, right_z;
    comp_t up_x, up_y, up_z;
    modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
        right_z, up_x, up_y, up_z, input ready);
    modport sink (input valid, forward_x, forward_y, forward_z, right_x, right_y,
        right_z, up_x, up_y, up_z, output ready);
endinterface

// File: hw/rtl/eab_cordic_lane.sv
// One CORDIC lane: pipelined sine/cosine of a binary angle, one step a stage.
// Depends on eab_pkg.
`timescale 1ns / 1ps
module eab_cordic_lane import eab_pkg::*; (
    input  logic            clk,
    input  logic            en,
    input  logic [IN_W-1:0] angle,
    output q_t              sin_val,
    output q_t              cos_val
);
    q_t x_reg [CORDIC_STEPS+1];
    q_t y_reg [CORDIC_STEPS+1];
    q_t z_reg [CORDIC_STEPS+1];
    logic [1:0] quad_reg [CORDIC_STEPS+1];
    logic [31:0] turn;

    assign turn = {angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= INV_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= CW'(signed'({1'b0, turn[29:0]}));
            quad_reg[0] <= turn[31:30];
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
                end
            end
        end
    end

    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0: begin cos_val = x_reg[CORDIC_STEPS];  sin_val = y_reg[CORDIC_STEPS]; end
            2'd1: begin cos_val = -y_reg[CORDIC_STEPS]; sin_val = x_reg[CORDIC_STEPS]; end
            2'd2: begin cos_val = -x_reg[CORDIC_STEPS]; sin_val = -y_reg[CORDIC_STEPS]; end
            default: begin cos_val = y_reg[CORDIC_STEPS]; sin_val = -x_reg[CORDIC_STEPS]; end
        endcase
    end
endmodule

// File: hw/rtl/eab_merge.sv
// Merge stage: combines lane sines/cosines into nine basis components.
// Three registered stages (inner products, outer products, sums). Depends on eab_pkg.
`timescale 1ns / 1ps
module eab_merge import eab_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  logic   mode,
    input  trig_t  trig,
    output comp_t  comp [9]
);
    trig_t t1_reg, t2_reg;
    logic m1_reg, m2_reg, m3_reg;
    q_t spcy_reg, spsy_reg, cpcy_reg, cpsy_reg;
    q_t a_reg [10];
    q_t v_reg [9];
    q_t msp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= trig;
            m1_reg   <= mode;
            spcy_reg <= qround(trig.sp * trig.cy);
            spsy_reg <= qround(trig.sp * trig.sy);
            cpcy_reg <= qround(trig.cp * trig.cy);
            cpsy_reg <= qround(trig.cp * trig.sy);
            t2_reg   <= t1_reg;
            m2_reg   <= m1_reg;
            a_reg[0] <= qround(t1_reg.sr * spcy_reg);
            a_reg[1] <= qround(t1_reg.cr * t1_reg.sy);
            a_reg[2] <= qround(t1_reg.sr * spsy_reg);
            a_reg[3] <= qround(t1_reg.cr * t1_reg.cy);
            a_reg[4] <= qround(t1_reg.sr * t1_reg.cp);
            a_reg[5] <= qround(t1_reg.cr * spcy_reg);
            a_reg[6] <= qround(t1_reg.sr * t1_reg.sy);
            a_reg[7] <= qround(t1_reg.cr * spsy_reg);
            a_reg[8] <= qround(t1_reg.sr * t1_reg.cy);
            a_reg[9] <= qround(t1_reg.cr * t1_reg.cp);
            v_reg[0] <= cpcy_reg;
            v_reg[1] <= cpsy_reg;
            msp_reg  <= -t1_reg.sp;
            m3_reg   <= m2_reg;
            if (!m2_reg)
            begin
                v_reg[3] <= a_reg[1] - a_reg[0];
                v_reg[4] <= -a_reg[2] - a_reg[3];
                v_reg[5] <= -a_reg[4];
                v_reg[6] <= a_reg[5] + a_reg[6];
                v_reg[7] <= a_reg[7] - a_reg[8];
                v_reg[8] <= a_reg[9];
            end
            else
            begin
                v_reg[3] <= a_reg[0] - a_reg[1];
                v_reg[4] <= a_reg[2] + a_reg[3];
                v_reg[5] <= a_reg[4];
                v_reg[6] <= a_reg[5] + a_reg[6];
                v_reg[7] <= a_reg[7] - a_reg[8];
                v_reg[8] <= a_reg[9];
            end
        end
    end

    // Hold first-row terms one extra stage to line up with the sums
    q_t c0_reg, c1_reg, sp3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg  <= v_reg[0];
            c1_reg  <= v_reg[1];
            sp3_reg <= msp_reg;
        end
    end

    always_comb
    begin
        comp[0] = to_field(c0_reg);
        if (!m3_reg)
        begin
            comp[1] = to_field(c1_reg);
            comp[2] = to_field(sp3_reg);
            comp[3] = to_field(v_reg[3]);
            comp[4] = to_field(v_reg[4]);
            comp[5] = to_field(v_reg[5]);
            comp[6] = to_field(v_reg[6]);
            comp[7] = to_field(v_reg[7]);
            comp[8] = to_field(v_reg[8]);
        end
        else
        begin
            comp[1] = to_field(v_reg[3]);
            comp[2] = to_field(v_reg[6]);
            comp[3] = to_field(c1_reg);
            comp[4] = to_field(v_reg[4]);
            comp[5] = to_field(v_reg[7]);
            comp[6] = to_field(sp3_reg);
            comp[7] = to_field(v_reg[5]);
            comp[8] = to_field(v_reg[8]);
        end
    end
endmodule

// File: hw/rtl/euler_angles_to_basis_vectors_top.sv
// Pipeline: each accepted word passes through 17 CORDIC stages and 3 merge
// stages before the output word can be taken.
// Throughput: one word per cycle; the pipeline advances whenever the output
// register is empty or being taken, so backpressure stalls all stages together.
// Reset: rst_n async active low clears valid bits and mode_reg.
// Depends on eab_pkg, eab_if, eab_cordic_lane, eab_merge.
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors_top import eab_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    eab_in_if.sink    in_ch,
    eab_out_if.source out_ch
);
    localparam int LAT = CORDIC_STEPS + 4;
    logic [LAT-1:0] vld_reg;
    logic mode_reg, en;
    trig_t trig;
    comp_t comp [9];

    assign en = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) mode_reg <= cfg_wdata;
            if (en) vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    eab_cordic_lane u_pitch (.clk, .en, .angle(in_ch.pitch_angle),
        .sin_val(trig.sp), .cos_val(trig.cp));
    eab_cordic_lane u_yaw (.clk, .en, .angle(in_ch.yaw_angle),
        .sin_val(trig.sy), .cos_val(trig.cy));
    eab_cordic_lane u_roll (.clk, .en, .angle(in_ch.roll_angle),
        .sin_val(trig.sr), .cos_val(trig.cr));

    eab_merge u_merge (.clk, .en, .mode(mode_reg), .trig, .comp);

    assign out_ch.valid = vld_reg[LAT-1];
    assign out_ch.forward_x = comp[0];
    assign out_ch.forward_y = comp[1];
    assign out_ch.forward_z = comp[2];
    assign out_ch.right_x = comp[3];
    assign out_ch.right_y = comp[4];
    assign out_ch.right_z = comp[5];
    assign out_ch.up_x = comp[6];
    assign out_ch.up_y = comp[7];
    assign out_ch.up_z = comp[8];
endmodule
